// ===== rtl/bpc_pkg.sv =====
// Shared types, register indexes and helpers for the button press classifier.
`timescale 1ns / 1ps

package bpc_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int CFG_WIDTH   = 16;
   localparam int CSR_IDX_W   = 3;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [CFG_WIDTH-1:0]   cfg_word_type;
   typedef logic [CSR_IDX_W-1:0]   csr_index_type;

   localparam count_type CNT_MAX = {COUNT_WIDTH{1'b1}};

   // register map
   localparam csr_index_type REG_DEBOUNCE_TICKS = 3'd0;
   localparam csr_index_type REG_HOLD_TICKS     = 3'd1;
   localparam csr_index_type REG_LOCKOUT_TICKS  = 3'd2;
   localparam csr_index_type REG_QUICK_ENABLE   = 3'd3;
   localparam csr_index_type REG_HOLD_ENABLE    = 3'd4;
   localparam csr_index_type REG_SECOND_ENABLE  = 3'd5;

   // reset values
   localparam cfg_word_type DEBOUNCE_RESET = 16'd50;
   localparam cfg_word_type HOLD_RESET     = 16'd500;
   localparam cfg_word_type LOCKOUT_RESET  = 16'd50;

   // countdown load: zero acts as one, oversized values saturate
   function automatic count_type load_value(input cfg_word_type v);
      logic [31:0] wide;
      wide = 32'(v);
      if (wide > 32'(CNT_MAX)) begin
         return CNT_MAX;
      end else if (wide == 32'd0) begin
         return count_type'(1);
      end else begin
         return count_type'(wide);
      end
   endfunction

endpackage

// ===== rtl/button_press_classifier_unit.sv =====
// Top level of the button press classifier: tick register, event logic, result register.
`timescale 1ns / 1ps

// Usage
// Each req_ item is one time tick carrying the raw direction and second button
// pin levels (low = pressed). Every tick yields exactly one rsp_ item with the
// quick, hold and second button event flags for that tick.
// Configuration is written over the csr_ channel (index, data); csr_ready is
// always high. Write only while no tick is in flight.
// A tick waits in the tick register until the result register can advance; it is
// then processed into the result register, where its result stays valid until the receiver takes it.
// Throughput: one tick per cycle while rsp_ready stays high, set by the combinational
// update of the debounce, hold and lockout counters between the tick and result registers.
// When rsp_ready is low the result holds and the tick register still takes
// one more tick; req_ready drops once both registers are full.
// Reset (synchronous, active high) empties both registers, clears the
// counters, sets last pin levels high and loads the register reset values.
module button_press_classifier_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_dir_level,
   input  logic                   req_second_level,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_quick_event,
   output logic                   rsp_hold_event,
   output logic                   rsp_second_event,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  bpc_pkg::csr_index_type csr_index,
   input  bpc_pkg::cfg_word_type  csr_data
);
   import bpc_pkg::*;

   // configuration
   cfg_word_type debounce_ticks_ff, hold_ticks_ff, lockout_ticks_ff;
   logic         quick_enable_ff, hold_enable_ff, second_enable_ff;

   // tick register and result register
   logic in_valid_ff, in_dir_ff, in_sec_ff;
   logic out_valid_ff, out_quick_ff, out_hold_ff, out_second_ff;

   // classifier state
   logic      last_dir_ff, settling_ff, pressed_seen_ff, hold_running_ff, last_sec_ff;
   count_type settle_count_ff, hold_count_ff, since_accept_ff;

   logic      settling_in, pressed_seen_in, hold_running_in;
   count_type settle_count_in, hold_count_in, since_accept_in;
   logic      quick_in, hold_in, second_in;

   logic advance, process;

   assign advance   = !out_valid_ff || rsp_ready;
   assign process   = advance && in_valid_ff;
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;

   assign rsp_valid        = out_valid_ff;
   assign rsp_quick_event  = out_quick_ff;
   assign rsp_hold_event   = out_hold_ff;
   assign rsp_second_event = out_second_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ticks_ff <= DEBOUNCE_RESET;
         hold_ticks_ff     <= HOLD_RESET;
         lockout_ticks_ff  <= LOCKOUT_RESET;
         quick_enable_ff   <= 1'b0;
         hold_enable_ff    <= 1'b0;
         second_enable_ff  <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_DEBOUNCE_TICKS: debounce_ticks_ff <= csr_data;
            REG_HOLD_TICKS:     hold_ticks_ff     <= csr_data;
            REG_LOCKOUT_TICKS:  lockout_ticks_ff  <= csr_data;
            REG_QUICK_ENABLE:   quick_enable_ff   <= csr_data[0];
            REG_HOLD_ENABLE:    hold_enable_ff    <= csr_data[0];
            REG_SECOND_ENABLE:  second_enable_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // one tick of the classifier
   always_comb begin
      settling_in     = settling_ff;
      settle_count_in = settle_count_ff;
      pressed_seen_in = pressed_seen_ff;
      hold_running_in = hold_running_ff;
      hold_count_in   = hold_count_ff;
      since_accept_in = since_accept_ff;
      quick_in        = 1'b0;
      hold_in         = 1'b0;
      second_in       = 1'b0;

      if (hold_running_ff) begin
         if (hold_count_ff <= count_type'(1)) begin
            hold_running_in = 1'b0;
            hold_count_in   = '0;
            hold_in         = hold_enable_ff;
         end else begin
            hold_count_in = hold_count_ff - count_type'(1);
         end
      end

      if (settling_ff) begin
         if (settle_count_ff <= count_type'(1)) begin
            settling_in     = 1'b0;
            settle_count_in = '0;
            if (!in_dir_ff && !pressed_seen_ff) begin
               quick_in        = 1'b1;
               hold_running_in = 1'b1;
               hold_count_in   = load_value(hold_ticks_ff);
               pressed_seen_in = 1'b1;
            end else if (in_dir_ff && pressed_seen_ff) begin
               hold_running_in = 1'b0;
               pressed_seen_in = 1'b0;
            end
         end else begin
            settle_count_in = settle_count_ff - count_type'(1);
         end
      end else if ((quick_enable_ff || hold_enable_ff) && (in_dir_ff != last_dir_ff)) begin
         settling_in     = 1'b1;
         settle_count_in = load_value(debounce_ticks_ff);
      end

      if (since_accept_ff != CNT_MAX) begin
         since_accept_in = since_accept_ff + count_type'(1);
      end
      if (second_enable_ff && last_sec_ff && !in_sec_ff &&
          (32'(since_accept_in) >= 32'(lockout_ticks_ff))) begin
         second_in       = 1'b1;
         since_accept_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         last_dir_ff     <= 1'b1;
         last_sec_ff     <= 1'b1;
         settling_ff     <= 1'b0;
         settle_count_ff <= '0;
         pressed_seen_ff <= 1'b0;
         hold_running_ff <= 1'b0;
         hold_count_ff   <= '0;
         since_accept_ff <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (process) begin
            last_dir_ff     <= in_dir_ff;
            last_sec_ff     <= in_sec_ff;
            settling_ff     <= settling_in;
            settle_count_ff <= settle_count_in;
            pressed_seen_ff <= pressed_seen_in;
            hold_running_ff <= hold_running_in;
            hold_count_ff   <= hold_count_in;
            since_accept_ff <= since_accept_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_dir_ff <= req_dir_level;
         in_sec_ff <= req_second_level;
      end
      if (process) begin
         out_quick_ff  <= quick_in;
         out_hold_ff   <= hold_in;
         out_second_ff <= second_in;
      end
   end

`ifndef SYNTH
   a_settle_nonzero: assert property (@(posedge clock) disable iff (reset)
      settling_ff |-> (settle_count_ff != '0))
      else $error("settle countdown running at zero");

   a_hold_nonzero: assert property (@(posedge clock) disable iff (reset)
      hold_running_ff |-> (hold_count_ff != '0))
      else $error("hold countdown running at zero");

   a_hold_needs_press: assert property (@(posedge clock) disable iff (reset)
      hold_running_ff |-> pressed_seen_ff)
      else $error("hold countdown running without a press");

   a_quick_starts_hold: assert property (@(posedge clock) disable iff (reset)
      (process && quick_in) |=> (pressed_seen_ff && hold_running_ff && out_quick_ff))
      else $error("quick event did not start hold countdown");

   a_second_clears_lockout: assert property (@(posedge clock) disable iff (reset)
      (process && second_in) |=> (since_accept_ff == '0))
      else $error("second event did not restart lockout counter");
`endif

endmodule

// ===== bench/bpc_event_checker.sv =====
// Checker for the button press classifier: predicts each tick's events, compares results.
`timescale 1ns / 1ps

module bpc_event_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_dir_level,
   input  logic                   req_second_level,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic                   rsp_quick_event,
   input  logic                   rsp_hold_event,
   input  logic                   rsp_second_event,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  bpc_pkg::csr_index_type csr_index,
   input  bpc_pkg::cfg_word_type  csr_data,
   output int                     mismatches,
   output int                     outstanding
);
   import bpc_pkg::*;

   typedef struct packed {
      logic quick;
      logic hold;
      logic second;
   } tick_events_type;

   // shadow registers
   cfg_word_type debounce_cfg;
   cfg_word_type hold_cfg;
   cfg_word_type lockout_cfg;
   logic         quick_en;
   logic         hold_en;
   logic         second_en;

   // shadow classifier state
   logic      last_dir;
   logic      settling;
   count_type settle_left;
   logic      pressed_seen;
   logic      hold_running;
   count_type hold_left;
   logic      last_sec;
   count_type since_accept;

   tick_events_type expected_events[$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   function automatic void clear_state();
      debounce_cfg = DEBOUNCE_RESET;
      hold_cfg     = HOLD_RESET;
      lockout_cfg  = LOCKOUT_RESET;
      quick_en     = 1'b0;
      hold_en      = 1'b0;
      second_en    = 1'b0;
      last_dir     = 1'b1;
      settling     = 1'b0;
      settle_left  = '0;
      pressed_seen = 1'b0;
      hold_running = 1'b0;
      hold_left    = '0;
      last_sec     = 1'b1;
      since_accept = '0;
   endfunction

   function automatic void apply_write(input csr_index_type idx, input cfg_word_type value);
      case (idx)
         REG_DEBOUNCE_TICKS: debounce_cfg = value;
         REG_HOLD_TICKS:     hold_cfg     = value;
         REG_LOCKOUT_TICKS:  lockout_cfg  = value;
         REG_QUICK_ENABLE:   quick_en     = value[0];
         REG_HOLD_ENABLE:    hold_en      = value[0];
         REG_SECOND_ENABLE:  second_en    = value[0];
         default: ;
      endcase
   endfunction

   // zero loads as one; register and counter share one width
   function automatic count_type countdown_load(input cfg_word_type value);
      return (value == '0) ? count_type'(1) : count_type'(value);
   endfunction

   function automatic tick_events_type classify_tick(input logic dir, input logic sec);
      tick_events_type ev;
      logic            pressed;
      ev = '0;

      if (hold_running) begin
         if (hold_left <= count_type'(1)) begin
            hold_running = 1'b0;
            hold_left    = '0;
            if (hold_en) ev.hold = 1'b1;
         end else begin
            hold_left = hold_left - count_type'(1);
         end
      end

      // an edge on the expiry tick is not seen
      if (settling) begin
         if (settle_left <= count_type'(1)) begin
            pressed     = ~dir;
            settling    = 1'b0;
            settle_left = '0;
            if (pressed && !pressed_seen) begin
               ev.quick     = 1'b1;
               hold_running = 1'b1;
               hold_left    = countdown_load(hold_cfg);
               pressed_seen = 1'b1;
            end else if (!pressed && pressed_seen) begin
               hold_running = 1'b0;
               pressed_seen = 1'b0;
            end
         end else begin
            settle_left = settle_left - count_type'(1);
         end
      end else if ((quick_en || hold_en) && dir != last_dir) begin
         settling    = 1'b1;
         settle_left = countdown_load(debounce_cfg);
      end

      if (since_accept != CNT_MAX) since_accept = since_accept + count_type'(1);
      if (second_en && last_sec && !sec && since_accept >= count_type'(lockout_cfg)) begin
         ev.second    = 1'b1;
         since_accept = '0;
      end

      last_dir = dir;
      last_sec = sec;
      return ev;
   endfunction

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      tick_events_type want;
      if (reset) begin
         clear_state();
         expected_events.delete();
      end else begin
         if (csr_valid && csr_ready) apply_write(csr_index, csr_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               report("result item with no tick waiting");
            end else begin
               want = expected_events.pop_front();
               if (rsp_quick_event !== want.quick)
                  report($sformatf("quick_event got %b want %b", rsp_quick_event, want.quick));
               if (rsp_hold_event !== want.hold)
                  report($sformatf("hold_event got %b want %b", rsp_hold_event, want.hold));
               if (rsp_second_event !== want.second)
                  report($sformatf("second_event got %b want %b",
                                   rsp_second_event, want.second));
            end
         end
         if (req_valid && req_ready)
            expected_events.push_back(classify_tick(req_dir_level, req_second_level));
      end
      outstanding <= expected_events.size();
   end

endmodule

// ===== bench/button_press_classifier_unit_test.sv =====
// Testbench top for the button press classifier: clock, reset, stimulus, verdict.
`timescale 1ns / 1ps

module button_press_classifier_unit_test;
   import bpc_pkg::*;

   localparam int            CYCLE_LIMIT = 200000;
   localparam int            PHASES      = 8;
   localparam int            PHASE_TICKS = 120;
   localparam int            SQUEEZE_LEN = 80;
   localparam csr_index_type REG_SPARE_A = 3'd6;
   localparam csr_index_type REG_SPARE_B = 3'd7;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_dir_level = 1'b1;
   logic          req_second_level = 1'b1;
   logic          rsp_ready = 1'b1;
   logic          csr_valid = 1'b0;
   csr_index_type csr_index = '0;
   cfg_word_type  csr_data = '0;

   logic req_ready;
   logic rsp_valid;
   logic rsp_quick_event;
   logic rsp_hold_event;
   logic rsp_second_event;
   logic csr_ready;

   int mismatches;
   int outstanding;
   int cycle_count = 0;

   bit calm = 1'b0;     // no idling on either side
   bit squeeze = 1'b0;  // request one long receiver hold-off

   // pin pattern generator state
   logic dir_now = 1'b1;
   logic sec_now = 1'b1;
   int   dir_run = 0;
   int   sec_run = 0;
   int   run_max = 8;

   csr_index_type write_idx[$];
   cfg_word_type  write_val[$];

   button_press_classifier_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_dir_level    (req_dir_level),
      .req_second_level (req_second_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_quick_event  (rsp_quick_event),
      .rsp_hold_event   (rsp_hold_event),
      .rsp_second_event (rsp_second_event),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   bpc_event_checker u_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_dir_level    (req_dir_level),
      .req_second_level (req_second_level),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_quick_event  (rsp_quick_event),
      .rsp_hold_event   (rsp_hold_event),
      .rsp_second_event (rsp_second_event),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatches       (mismatches),
      .outstanding      (outstanding)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("button_press_classifier_unit verification failed");
         $finish;
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      int span;
      forever begin
         if (squeeze) begin
            squeeze = 1'b0;
            rsp_ready <= 1'b0;
            span = SQUEEZE_LEN;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            span = $urandom_range(1, 8);
         end else begin
            rsp_ready <= 1'b1;
            span = calm ? 1 : $urandom_range(1, 12);
         end
         repeat (span) @(posedge clock);
      end
   end

   // drive queued register writes back to back
   task automatic flush_writes();
      while (write_idx.size() != 0) begin
         csr_valid <= 1'b1;
         csr_index <= write_idx.pop_front();
         csr_data  <= write_val.pop_front();
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic program_settings(input cfg_word_type deb, input cfg_word_type hold,
                                   input cfg_word_type lock, input logic q_en,
                                   input logic h_en, input logic s_en);
      cfg_word_type junk;
      junk = cfg_word_type'($urandom_range(0, 65535)) & 16'hFFFE;
      write_idx.push_back(REG_DEBOUNCE_TICKS);  write_val.push_back(deb);
      write_idx.push_back(REG_HOLD_TICKS);      write_val.push_back(hold);
      write_idx.push_back(REG_LOCKOUT_TICKS);   write_val.push_back(lock);
      // only bit 0 of an enable counts; upper bits carry noise
      write_idx.push_back(REG_QUICK_ENABLE);    write_val.push_back(junk | cfg_word_type'(q_en));
      write_idx.push_back(REG_HOLD_ENABLE);     write_val.push_back(junk | cfg_word_type'(h_en));
      write_idx.push_back(REG_SECOND_ENABLE);   write_val.push_back(junk | cfg_word_type'(s_en));
      flush_writes();
   endtask

   task automatic send_tick(input logic dir, input logic sec);
      req_valid        <= 1'b1;
      req_dir_level    <= dir;
      req_second_level <= sec;
      do @(posedge clock); while (!req_ready);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   // held levels of random length, with short bounce runs mixed in
   task automatic play_ticks(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         if (dir_run == 0) begin
            dir_now = ~dir_now;
            dir_run = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2)
                                                  : $urandom_range(1, run_max);
         end
         if (sec_run == 0) begin
            sec_now = ~sec_now;
            sec_run = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2)
                                                  : $urandom_range(1, run_max);
         end
         dir_run--;
         sec_run--;
         send_tick(dir_now, sec_now);
      end
   endtask

   initial begin
      logic [19:0]  dir_pat;
      logic [19:0]  sec_pat;
      int           phase;
      int           k;
      cfg_word_type deb;
      cfg_word_type hold;
      dir_pat = 20'b1000_0000_1111_0100_0011;
      sec_pat = 20'b1010_1101_1001_1010_1111;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: all detection off, so pin activity yields nothing
      send_tick(1'b0, 1'b0);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      drain();

      write_idx.push_back(REG_SPARE_A);
      write_val.push_back(cfg_word_type'($urandom_range(0, 65535)));
      write_idx.push_back(REG_SPARE_B);
      write_val.push_back(cfg_word_type'($urandom_range(0, 65535)));
      flush_writes();

      // press, hold through expiry, release, bounce; second edges in and out of lockout
      program_settings(16'd2, 16'd3, 16'd2, 1'b1, 1'b1, 1'b1);
      for (k = 19; k >= 0; k--) send_tick(dir_pat[k], sec_pat[k]);
      drain();

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               program_settings(cfg_word_type'($urandom_range(0, 4)), 16'd6,
                                cfg_word_type'($urandom_range(0, 8)), 1'b1, 1'b0, 1'b0);
               run_max = 12;
            end
            1: begin
               program_settings('1, '1, '1, 1'b1, 1'b1, 1'b1);
               run_max = 10;
            end
            2: begin
               program_settings(16'd1, 16'd1, 16'd0, 1'b1, 1'b1, 1'b1);
               run_max = 4;
            end
            3: begin
               program_settings(16'd0, 16'd0, 16'd1, 1'b0, 1'b1, 1'b1);
               run_max = 5;
            end
            default: begin
               deb  = cfg_word_type'($urandom_range(0, 6));
               hold = cfg_word_type'($urandom_range(0, 20));
               program_settings(deb, hold, cfg_word_type'($urandom_range(0, 12)),
                                $urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                                $urandom_range(0, 3) != 0);
               run_max = deb + hold + 4;
            end
         endcase
         if (phase == 4) squeeze = 1'b1;
         if (phase == PHASES - 1) calm = 1'b1;
         play_ticks(PHASE_TICKS);
         drain();
      end

      repeat (6) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("button_press_classifier_unit verification clean");
      end else begin
         $display("button_press_classifier_unit verification failed");
      end
      $finish;
   end

endmodule
